// File: rtl/core/rhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pkg
// Shared constants, codes and port structs of the record heap sorter.
// ----------------------------------------------------------------------------
package rhs_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int NAME_BYTES  = 128;

    localparam int REC_W   = $clog2(MAX_RECORDS);        // record index
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);    // record count
    localparam int LEN_W   = $clog2(NAME_BYTES);         // name length
    localparam int NAME_AW = REC_W + 1 + LEN_W;          // name store address

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    localparam logic [1:0] REQ_NAME  = 2'd0;
    localparam logic [1:0] REQ_CLOSE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    typedef struct packed {
        logic               we;
        logic [REC_W-1:0]   waddr;
        logic [REC_W-1:0]   wdata;
        logic [REC_W-1:0]   raddr;
    } perm_port_t;

    typedef struct packed {
        logic               start;
        logic [REC_W-1:0]   a;
        logic [REC_W-1:0]   b;
    } cmp_req_t;

    typedef struct packed {
        logic               done;
        logic               gt;
    } cmp_rsp_t;

    typedef struct packed {
        logic               en;
        logic [NAME_AW-1:0] addr;
        logic [7:0]         data;
    } name_wr_t;

    typedef struct packed {
        logic               en;
        logic [REC_W-1:0]   addr;
        logic [2*LEN_W-1:0] data;   // family length high, given length low
    } len_wr_t;

endpackage

// File: rtl/core/rhs_keys.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_keys
// Name and length stores plus a bytewise key comparator (family, then given).
// ----------------------------------------------------------------------------
module rhs_keys
(
    input  logic              clk,
    input  logic              rst_n,
    input  rhs_pkg::name_wr_t name_wr,
    input  rhs_pkg::len_wr_t  len_wr,
    input  rhs_pkg::cmp_req_t cmp_req,
    output rhs_pkg::cmp_rsp_t cmp_rsp
);

    typedef enum logic [3:0]
    {
        C_IDLE = 4'b0001,
        C_LEN  = 4'b0010,
        C_BYTE = 4'b0100,
        C_CHK  = 4'b1000
    } cmp_state_t;

    logic [7:0] name_mem [0:(1 << rhs_pkg::NAME_AW) - 1];
    logic [2*rhs_pkg::LEN_W-1:0] len_mem [0:rhs_pkg::MAX_RECORDS-1];

    cmp_state_t state_reg, state_next;
    logic [rhs_pkg::REC_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [2*rhs_pkg::LEN_W-1:0] la_reg, la_next, lb_reg, lb_next;
    logic                        sel_reg, sel_next;
    logic [rhs_pkg::LEN_W-1:0]   k_reg, k_next;
    logic                        done_reg, done_next, gt_reg, gt_next;

    logic [7:0]                  qa, qb;
    logic [2*rhs_pkg::LEN_W-1:0] lqa, lqb;
    logic [rhs_pkg::LEN_W-1:0]   cur_la, cur_lb, nmin;

    always_ff @(posedge clk)
    begin
        if (name_wr.en)
        begin
            name_mem[name_wr.addr] <= name_wr.data;
        end
        qa <= name_mem[{a_reg, sel_reg, k_reg}];
        qb <= name_mem[{b_reg, sel_reg, k_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (len_wr.en)
        begin
            len_mem[len_wr.addr] <= len_wr.data;
        end
        lqa <= len_mem[cmp_req.a];
        lqb <= len_mem[cmp_req.b];
    end

    assign cur_la = sel_reg ? la_reg[rhs_pkg::LEN_W-1:0]
                            : la_reg[2*rhs_pkg::LEN_W-1:rhs_pkg::LEN_W];
    assign cur_lb = sel_reg ? lb_reg[rhs_pkg::LEN_W-1:0]
                            : lb_reg[2*rhs_pkg::LEN_W-1:rhs_pkg::LEN_W];
    assign nmin   = (cur_la < cur_lb) ? cur_la : cur_lb;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        sel_next   = sel_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        gt_next    = gt_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (cmp_req.start)
                begin
                    a_next     = cmp_req.a;
                    b_next     = cmp_req.b;
                    state_next = C_LEN;
                end
            end
            C_LEN:
            begin
                la_next    = lqa;
                lb_next    = lqb;
                sel_next   = 1'b0;
                k_next     = '0;
                state_next = C_BYTE;
            end
            C_BYTE:
            begin
                if (k_reg == nmin)
                begin
                    if (cur_la != cur_lb)
                    begin
                        done_next  = 1'b1;
                        gt_next    = cur_la > cur_lb;
                        state_next = C_IDLE;
                    end
                    else if (!sel_reg)
                    begin
                        sel_next = 1'b1;
                        k_next   = '0;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        gt_next    = 1'b0;
                        state_next = C_IDLE;
                    end
                end
                else
                begin
                    state_next = C_CHK;
                end
            end
            C_CHK:
            begin
                if (qa != qb)
                begin
                    done_next  = 1'b1;
                    gt_next    = qa > qb;
                    state_next = C_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = C_BYTE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        la_reg  <= la_next;
        lb_reg  <= lb_next;
        sel_reg <= sel_next;
        k_reg   <= k_next;
        gt_reg  <= gt_next;
    end

    assign cmp_rsp.done = done_reg;
    assign cmp_rsp.gt   = gt_reg;

endmodule

// File: rtl/core/rhs_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_sorter
// Permutation memory and 1-based binary max-heap sort sequencer.
// ----------------------------------------------------------------------------
module rhs_sorter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rhs_pkg::CNT_W-1:0]   count,
    input  rhs_pkg::perm_port_t         ext,
    output logic [rhs_pkg::REC_W-1:0]   perm_q,
    output rhs_pkg::cmp_req_t           cmp_req,
    input  rhs_pkg::cmp_rsp_t           cmp_rsp,
    output logic                        done
);

    typedef enum logic [12:0]
    {
        S_IDLE  = 13'b0000000000001,
        S_OUTER = 13'b0000000000010,
        S_SIFT  = 13'b0000000000100,
        S_SL    = 13'b0000000001000,
        S_WL    = 13'b0000000010000,
        S_SR    = 13'b0000000100000,
        S_WR    = 13'b0000001000000,
        S_DEC   = 13'b0000010000000,
        S_SW2   = 13'b0000100000000,
        S_RET   = 13'b0001000000000,
        S_XRD   = 13'b0010000000000,
        S_XW1   = 13'b0100000000000,
        S_XW2   = 13'b1000000000000
    } sort_state_t;

    localparam int CW = rhs_pkg::CNT_W;
    localparam int RW = rhs_pkg::REC_W;

    logic [RW-1:0] perm_mem [0:rhs_pkg::MAX_RECORDS-1];

    sort_state_t state_reg, state_next;
    logic          phase_reg, phase_next;      // 0 build, 1 extract
    logic [CW-1:0] n_reg, n_next, bi_reg, bi_next, si_reg, si_next, hn_reg, hn_next;
    logic [CW-1:0] bigpos_reg, bigpos_next;
    logic [RW-1:0] pi_reg, pi_next, pl_reg, pl_next, bigval_reg, bigval_next;
    logic          done_reg, done_next;

    logic [CW:0]   l, r;
    logic [RW-1:0] ra, rb, qa, qb, waddr, wdata;
    logic          we;

    assign l = {si_reg, 1'b0};
    assign r = l + 1'b1;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_mem[waddr] <= wdata;
        end
        qa <= perm_mem[ra];
        qb <= perm_mem[rb];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        n_next      = n_reg;
        bi_next     = bi_reg;
        si_next     = si_reg;
        hn_next     = hn_reg;
        bigpos_next = bigpos_reg;
        pi_next     = pi_reg;
        pl_next     = pl_reg;
        bigval_next = bigval_reg;
        done_next   = 1'b0;
        ra          = ext.raddr;
        rb          = '0;
        we          = 1'b0;
        waddr       = ext.waddr;
        wdata       = ext.wdata;
        cmp_req     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                we = ext.we;
                if (start)
                begin
                    n_next     = count;
                    bi_next    = count >> 1;
                    phase_next = 1'b0;
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                if (!phase_reg)
                begin
                    if (bi_reg != '0)
                    begin
                        si_next    = bi_reg;
                        hn_next    = n_reg;
                        state_next = S_SIFT;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        bi_next    = n_reg;
                    end
                end
                else if (bi_reg > CW'(1))
                begin
                    state_next = S_XRD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SIFT:
            begin
                ra = RW'(si_reg - 1'b1);
                rb = RW'(l - 1'b1);
                if (l > {1'b0, hn_reg})
                begin
                    state_next = S_RET;
                end
                else
                begin
                    state_next = S_SL;
                end
            end
            S_SL:
            begin
                pi_next       = qa;
                pl_next       = qb;
                cmp_req.start = 1'b1;
                cmp_req.a     = qb;
                cmp_req.b     = qa;
                state_next    = S_WL;
            end
            S_WL:
            begin
                ra = RW'(r - 1'b1);
                if (cmp_rsp.done)
                begin
                    if (cmp_rsp.gt)
                    begin
                        bigpos_next = l[CW-1:0];
                        bigval_next = pl_reg;
                    end
                    else
                    begin
                        bigpos_next = si_reg;
                        bigval_next = pi_reg;
                    end
                    state_next = (r <= {1'b0, hn_reg}) ? S_SR : S_DEC;
                end
            end
            S_SR:
            begin
                pl_next       = qa;
                cmp_req.start = 1'b1;
                cmp_req.a     = qa;
                cmp_req.b     = bigval_reg;
                state_next    = S_WR;
            end
            S_WR:
            begin
                if (cmp_rsp.done)
                begin
                    if (cmp_rsp.gt)
                    begin
                        bigpos_next = r[CW-1:0];
                        bigval_next = pl_reg;
                    end
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (bigpos_reg == si_reg)
                begin
                    state_next = S_RET;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = RW'(si_reg - 1'b1);
                    wdata      = bigval_reg;
                    state_next = S_SW2;
                end
            end
            S_SW2:
            begin
                we         = 1'b1;
                waddr      = RW'(bigpos_reg - 1'b1);
                wdata      = pi_reg;
                si_next    = bigpos_reg;
                state_next = S_SIFT;
            end
            S_RET:
            begin
                bi_next    = bi_reg - 1'b1;
                state_next = S_OUTER;
            end
            S_XRD:
            begin
                ra         = '0;
                rb         = RW'(bi_reg - 1'b1);
                state_next = S_XW1;
            end
            S_XW1:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = qb;
                pi_next    = qa;
                state_next = S_XW2;
            end
            S_XW2:
            begin
                we         = 1'b1;
                waddr      = RW'(bi_reg - 1'b1);
                wdata      = pi_reg;
                si_next    = CW'(1);
                hn_next    = bi_reg - 1'b1;
                state_next = S_SIFT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        n_reg      <= n_next;
        bi_reg     <= bi_next;
        si_reg     <= si_next;
        hn_reg     <= hn_next;
        bigpos_reg <= bigpos_next;
        pi_reg     <= pi_next;
        pl_reg     <= pl_next;
        bigval_reg <= bigval_next;
    end

    assign perm_q = qa;
    assign done   = done_reg;

endmodule

// File: rtl/core/record_heap_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_heap_sort
// Contact record loader, heap sorter by name key and sorted-rank reader.
// ----------------------------------------------------------------------------
// Load, reserved and out-of-range read items give their registered result in
// the next cycle; a read in range passes through T_RD1 and T_RD2 first.
// Throughput: loads take one per cycle while busy is low; a read holds busy
// high through T_RD1 and T_RD2, so the next transfer waits for both.
// A final close keeps busy high for the whole heap sort, set by the compare
// sequencer (C_BYTE and C_CHK for each name byte compared) and the single-port
// permutation writes. Asynchronous active-low reset empties the batch.
// Results cannot be stalled: done marks each one for exactly one cycle.
// ----------------------------------------------------------------------------
module record_heap_sort
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic        name_select,
    input  logic [7:0]  name_byte,
    input  logic [15:0] dial_country,
    input  logic [15:0] dial_area,
    input  logic signed [63:0] phone_number,
    input  logic        final_record,
    input  logic [5:0]  read_rank,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  record_index,
    output logic [15:0] country_out,
    output logic [15:0] area_out,
    output logic signed [63:0] number_out
);

    typedef enum logic [3:0]
    {
        T_IDLE = 4'b0001,
        T_SORT = 4'b0010,
        T_RD1  = 4'b0100,
        T_RD2  = 4'b1000
    } top_state_t;

    localparam int CW = rhs_pkg::CNT_W;
    localparam int RW = rhs_pkg::REC_W;
    localparam int LW = rhs_pkg::LEN_W;

    // phone fields per record
    logic [31:0] codes_mem  [0:rhs_pkg::MAX_RECORDS-1];
    logic [63:0] number_mem [0:rhs_pkg::MAX_RECORDS-1];
    logic [31:0] codes_q;
    logic [63:0] number_q;

    top_state_t state_reg, state_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic          ovf_reg, ovf_next, sorted_reg, sorted_next;
    logic [LW-1:0] fam_len_reg, fam_len_next, giv_len_reg, giv_len_next;
    logic [RW-1:0] rec_reg, rec_next;

    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [5:0]    index_reg, index_next;
    logic [15:0]   country_reg, country_next, area_reg, area_next;
    logic [63:0]   number_reg, number_next;

    logic          accept;
    logic [CW-1:0] rc_e;
    logic [LW-1:0] fam_e, giv_e, len_sel;
    logic          ovf_e;
    logic          rec_we;

    rhs_pkg::name_wr_t   name_wr;
    rhs_pkg::len_wr_t    len_wr;
    rhs_pkg::cmp_req_t   cmp_req;
    rhs_pkg::cmp_rsp_t   cmp_rsp;
    rhs_pkg::perm_port_t perm_port;
    logic [RW-1:0]       perm_q;
    logic                sort_start, sort_done;

    rhs_keys u_keys
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .name_wr (name_wr),
        .len_wr  (len_wr),
        .cmp_req (cmp_req),
        .cmp_rsp (cmp_rsp)
    );

    rhs_sorter u_sorter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .count   (rc_next),
        .ext     (perm_port),
        .perm_q  (perm_q),
        .cmp_req (cmp_req),
        .cmp_rsp (cmp_rsp),
        .done    (sort_done)
    );

    assign busy   = (state_reg != T_IDLE);
    assign accept = start && !busy;

    // a load after a finished sort opens a new batch first
    assign rc_e    = sorted_reg ? '0 : rc_reg;
    assign ovf_e   = sorted_reg ? 1'b0 : ovf_reg;
    assign fam_e   = sorted_reg ? '0 : fam_len_reg;
    assign giv_e   = sorted_reg ? '0 : giv_len_reg;
    assign len_sel = name_select ? giv_e : fam_e;

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            codes_mem[RW'(rc_e)]  <= {dial_country, dial_area};
            number_mem[RW'(rc_e)] <= phone_number;
        end
        codes_q  <= codes_mem[perm_q];
        number_q <= number_mem[perm_q];
    end

    always_comb
    begin
        state_next    = state_reg;
        rc_next       = rc_reg;
        ovf_next      = ovf_reg;
        sorted_next   = sorted_reg;
        fam_len_next  = fam_len_reg;
        giv_len_next  = giv_len_reg;
        rec_next      = rec_reg;
        done_next     = 1'b0;
        status_next   = rhs_pkg::ST_OK;
        index_next    = '0;
        country_next  = '0;
        area_next     = '0;
        number_next   = '0;
        rec_we        = 1'b0;
        sort_start    = 1'b0;
        name_wr.en    = 1'b0;
        name_wr.addr  = {RW'(rc_e), name_select, len_sel};
        name_wr.data  = name_byte;
        len_wr.en     = 1'b0;
        len_wr.addr   = RW'(rc_e);
        len_wr.data   = {fam_e, giv_e};
        perm_port.we    = 1'b0;
        perm_port.waddr = RW'(rc_e);
        perm_port.wdata = RW'(rc_e);
        perm_port.raddr = read_rank;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (req_type) inside
                        rhs_pkg::REQ_NAME, rhs_pkg::REQ_CLOSE:
                        begin
                            rc_next      = rc_e;
                            ovf_next     = ovf_e;
                            sorted_next  = 1'b0;
                            fam_len_next = fam_e;
                            giv_len_next = giv_e;
                            if (req_type == rhs_pkg::REQ_NAME)
                            begin
                                if (name_byte != 8'd0)
                                begin
                                    if (rc_e == rhs_pkg::CNT_MAX
                                        || len_sel >= rhs_pkg::LEN_MAX)
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        name_wr.en = 1'b1;
                                        if (name_select)
                                        begin
                                            giv_len_next = giv_e + 1'b1;
                                        end
                                        else
                                        begin
                                            fam_len_next = fam_e + 1'b1;
                                        end
                                    end
                                end
                            end
                            else
                            begin
                                if (rc_e == rhs_pkg::CNT_MAX)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    rec_we       = 1'b1;
                                    len_wr.en    = 1'b1;
                                    perm_port.we = 1'b1;
                                    rc_next      = rc_e + 1'b1;
                                    fam_len_next = '0;
                                    giv_len_next = '0;
                                end
                                if (final_record)
                                begin
                                    sort_start = 1'b1;
                                    state_next = T_SORT;
                                end
                            end
                            status_next = ovf_next ? rhs_pkg::ST_OVF : rhs_pkg::ST_OK;
                        end
                        rhs_pkg::REQ_READ:
                        begin
                            if ({1'b0, read_rank} >= rc_reg)
                            begin
                                status_next = rhs_pkg::ST_RANGE;
                            end
                            else
                            begin
                                // result comes from the read pipeline
                                done_next  = 1'b0;
                                state_next = T_RD1;
                            end
                        end
                        default:
                        begin
                            status_next = rhs_pkg::ST_OK;
                        end
                    endcase
                end
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    sorted_next = 1'b1;
                    state_next  = T_IDLE;
                end
            end
            T_RD1:
            begin
                rec_next   = perm_q;
                state_next = T_RD2;
            end
            T_RD2:
            begin
                done_next    = 1'b1;
                status_next  = ovf_reg ? rhs_pkg::ST_OVF : rhs_pkg::ST_OK;
                index_next   = rec_reg;
                country_next = codes_q[31:16];
                area_next    = codes_q[15:0];
                number_next  = number_q;
                state_next   = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            rc_reg      <= '0;
            ovf_reg     <= 1'b0;
            sorted_reg  <= 1'b0;
            fam_len_reg <= '0;
            giv_len_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rc_reg      <= rc_next;
            ovf_reg     <= ovf_next;
            sorted_reg  <= sorted_next;
            fam_len_reg <= fam_len_next;
            giv_len_reg <= giv_len_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg     <= rec_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        country_reg <= country_next;
        area_reg    <= area_next;
        number_reg  <= number_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign record_index = index_reg;
    assign country_out  = country_reg;
    assign area_out     = area_reg;
    assign number_out   = number_reg;

endmodule

// File: dv/record_heap_sort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_heap_sort_tb
// Self-checking bench for the record heap sorter: directed table, then random
// record batches (short names, ties, overflow), sorts and sorted-rank reads.
// ----------------------------------------------------------------------------
module record_heap_sort_tb;

    import rhs_pkg::*;

    localparam int  ITEM_TARGET = 2000;
    localparam int  CALM_ITEMS  = 200;        // last items go with no idling
    localparam int  DRAIN_WAIT  = 20;
    localparam longint CYCLE_LIMIT = 3_000_000;

    // One input transfer and one result, at the port widths.
    typedef struct {
        logic [1:0]         rt;
        logic               sel;
        logic [7:0]         nb;
        logic [15:0]        cc;
        logic [15:0]        ac;
        logic signed [63:0] num;
        logic               fin;
        logic [5:0]         rank;
    } req_t;

    typedef struct {
        logic [1:0]         st;
        logic [5:0]         idx;
        logic [15:0]        co;
        logic [15:0]        ao;
        logic signed [63:0] no;
    } res_t;

    typedef struct {
        req_t r;
        bit   fixed;      // expected result typed in the row
        res_t e;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic               name_select;
    logic [7:0]         name_byte;
    logic [15:0]        dial_country;
    logic [15:0]        dial_area;
    logic signed [63:0] phone_number;
    logic               final_record;
    logic [5:0]         read_rank;
    logic               done;
    logic [1:0]         status;
    logic [5:0]         record_index;
    logic [15:0]        country_out;
    logic [15:0]        area_out;
    logic signed [63:0] number_out;

    record_heap_sort DUT (.*);

    // ------------------------------------------------------------------
    // Shadow of the contact store and the batch state
    // ------------------------------------------------------------------
    logic [7:0]         names  [MAX_RECORDS][2][NAME_BYTES];
    int unsigned        nlen   [MAX_RECORDS][2];
    logic [15:0]        cc_mem [MAX_RECORDS];
    logic [15:0]        ac_mem [MAX_RECORDS];
    logic signed [63:0] num_mem[MAX_RECORDS];
    int unsigned        perm   [MAX_RECORDS];
    int unsigned        rec_cnt;
    bit                 ovf;
    bit                 sorted;

    res_t   pending_results[$];
    int     errors;
    int     items_sent;
    longint cycles = 0;

    // Family name first, then given name; bytewise unsigned, shorter prefix
    // orders first.
    function automatic int name_order(int unsigned a, int unsigned b);
        int unsigned la, lb, n;
        for (int s = 0; s < 2; s++)
        begin
            la = nlen[a][s];
            lb = nlen[b][s];
            n  = (la < lb) ? la : lb;
            for (int unsigned k = 0; k < n; k++)
                if (names[a][s][k] != names[b][s][k])
                    return (names[a][s][k] < names[b][s][k]) ? -1 : 1;
            if (la != lb)
                return (la < lb) ? -1 : 1;
        end
        return 0;
    endfunction

    // 1-based sift down over perm[]
    function automatic void heap_down(int unsigned i, int unsigned n);
        int unsigned l, r, big, t;
        forever
        begin
            l = 2 * i;
            r = l + 1;
            big = i;
            if (l <= n && name_order(perm[l-1], perm[i-1]) > 0)
                big = l;
            if (r <= n && name_order(perm[r-1], perm[big-1]) > 0)
                big = r;
            if (big == i)
                return;
            t = perm[i-1];
            perm[i-1] = perm[big-1];
            perm[big-1] = t;
            i = big;
        end
    endfunction

    function automatic void heap_sort_names();
        int unsigned t;
        for (int unsigned i = rec_cnt / 2; i >= 1; i--)
            heap_down(i, rec_cnt);
        for (int unsigned i = rec_cnt; i >= 2; i--)
        begin
            t = perm[0];
            perm[0] = perm[i-1];
            perm[i-1] = t;
            heap_down(1, i - 1);
        end
    endfunction

    // Applies one transfer to the shadow state, returns the expected result.
    function automatic res_t contact_step(req_t q);
        res_t o;
        int unsigned len;
        o = '{default: '0};
        if (q.rt == REQ_NAME || q.rt == REQ_CLOSE)
        begin
            if (sorted)
            begin
                // a load after a sort opens a new batch
                rec_cnt = 0;
                ovf = 0;
                sorted = 0;
                foreach (nlen[i, s])
                    nlen[i][s] = 0;
            end
            if (q.rt == REQ_NAME)
            begin
                if (q.nb != 8'd0)
                begin
                    if (rec_cnt >= MAX_RECORDS)
                        ovf = 1;
                    else
                    begin
                        len = nlen[rec_cnt][q.sel];
                        if (len >= NAME_BYTES - 1)
                            ovf = 1;
                        else
                        begin
                            names[rec_cnt][q.sel][len] = q.nb;
                            nlen[rec_cnt][q.sel] = len + 1;
                        end
                    end
                end
            end
            else
            begin
                if (rec_cnt >= MAX_RECORDS)
                    ovf = 1;
                else
                begin
                    cc_mem[rec_cnt]  = q.cc;
                    ac_mem[rec_cnt]  = q.ac;
                    num_mem[rec_cnt] = q.num;
                    perm[rec_cnt]    = rec_cnt;
                    rec_cnt++;
                end
                if (q.fin)
                begin
                    heap_sort_names();
                    sorted = 1;
                end
            end
            o.st = ovf ? ST_OVF : ST_OK;
        end
        else if (q.rt == REQ_READ)
        begin
            if (q.rank >= rec_cnt)
                o.st = ST_RANGE;
            else
            begin
                o.st  = ovf ? ST_OVF : ST_OK;
                o.idx = perm[q.rank][5:0];
                o.co  = cc_mem[perm[q.rank]];
                o.ao  = ac_mem[perm[q.rank]];
                o.no  = num_mem[perm[q.rank]];
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("ERROR @%0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each done pulse is one transfer out, matched in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("ERROR @%0t: result with no expectation", $time);
            end
            else
            begin
                w = pending_results.pop_front();
                if (status !== w.st)
                    report_mismatch("status", 64'(status), 64'(w.st));
                if (record_index !== w.idx)
                    report_mismatch("record_index", 64'(record_index), 64'(w.idx));
                if (country_out !== w.co)
                    report_mismatch("country_out", 64'(country_out), 64'(w.co));
                if (area_out !== w.ao)
                    report_mismatch("area_out", 64'(area_out), 64'(w.ao));
                if (number_out !== w.no)
                    report_mismatch("number_out", number_out, w.no);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Drives one transfer, holds start until busy is seen low at an edge,
    // then queues the expectation. start stays high into the next item
    // unless an idle burst follows.
    task automatic send(req_t q, bit fixed, res_t e);
        res_t p;
        req_type     <= q.rt;
        name_select  <= q.sel;
        name_byte    <= q.nb;
        dial_country <= q.cc;
        dial_area    <= q.ac;
        phone_number <= q.num;
        final_record <= q.fin;
        read_rank    <= q.rank;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        p = contact_step(q);
        pending_results.push_back(fixed ? e : p);
        items_sent++;
        if (items_sent < ITEM_TARGET - CALM_ITEMS && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Random filler for fields the request type does not use.
    function automatic req_t noise_req();
        req_t q;
        q.rt   = REQ_NAME;
        q.sel  = 1'($urandom_range(0, 1));
        q.nb   = 8'($urandom_range(0, 255));
        q.cc   = 16'($urandom);
        q.ac   = 16'($urandom);
        q.num  = {$urandom, $urandom};
        q.fin  = 1'b0;
        q.rank = 6'($urandom_range(0, 63));
        return q;
    endfunction

    task automatic send_checked(req_t q);
        res_t none;
        none = '{default: '0};
        send(q, 1'b0, none);
    endtask

    // Name bytes from a tiny alphabet so that ties and shared prefixes are
    // common; now and then any byte value, zero included (ignored by the DUT).
    task automatic send_name(bit sel, int unsigned len);
        req_t q;
        for (int unsigned k = 0; k < len; k++)
        begin
            q = noise_req();
            q.sel = sel;
            if ($urandom_range(0, 9) != 0)
                q.nb = 8'h61 + 8'($urandom_range(0, 2));
            send_checked(q);
        end
    endtask

    // One batch of records, closed by a final close, then a burst of reads (with an occasional reserved type).
    task automatic run_batch();
        req_t q;
        int unsigned n, flen, glen;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        for (int unsigned r = 0; r < n; r++)
        begin
            // long names are rare: the longer ones overflow the name slot
            flen = ($urandom_range(0, 40) == 0) ? $urandom_range(125, 131)
                                                : $urandom_range(0, 4);
            glen = $urandom_range(0, 2);
            send_name(1'b0, flen);
            send_name(1'b1, glen);
            q = noise_req();
            q.rt  = REQ_CLOSE;
            q.fin = (r == n - 1);
            send_checked(q);
            // an occasional read mid-load sees load order
            if ($urandom_range(0, 11) == 0)
            begin
                q = noise_req();
                q.rt = REQ_READ;
                q.rank = 6'($urandom_range(0, r + 1));
                send_checked(q);
            end
        end
        repeat ($urandom_range(2, 10))
        begin
            q = noise_req();
            q.rt = ($urandom_range(0, 19) == 0) ? REQ_RSVD : REQ_READ;
            if ($urandom_range(0, 3) != 0)
                q.rank = 6'($urandom_range(0, (n > 63) ? 63 : n));
            send_checked(q);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic row_t mk(logic [1:0] rt, logic sel, logic [7:0] nb,
                                logic [15:0] cc, logic [15:0] ac,
                                logic signed [63:0] num, logic fin,
                                logic [5:0] rank, bit fixed, logic [1:0] st,
                                logic [5:0] idx, logic [15:0] co,
                                logic [15:0] ao, logic signed [63:0] no);
        row_t w;
        w.r = '{rt, sel, nb, cc, ac, num, fin, rank};
        w.fixed = fixed;
        w.e = '{st, idx, co, ao, no};
        return w;
    endfunction

    localparam logic signed [63:0] NUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] NUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    initial
    begin
        row_t plan[$];
        req_t q;
        bit   drained;

        start        = 1'b0;
        req_type     = REQ_NAME;
        name_select  = 1'b0;
        name_byte    = 8'd0;
        dial_country = 16'd0;
        dial_area    = 16'd0;
        phone_number = 64'sd0;
        final_record = 1'b0;
        read_rank    = 6'd0;
        errors       = 0;
        items_sent   = 0;
        rec_cnt      = 0;
        ovf          = 0;
        sorted       = 0;
        drained      = 1'b0;
        foreach (nlen[i, s])
            nlen[i][s] = 0;

        // read on an empty store, reserved type
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0, 0));
        plan.push_back(mk(REQ_RSVD, 1, 8'hFF, 16'hFFFF, 16'hFFFF, -1, 1, 6'd63,
                          1, ST_OK, 0, 0, 0, 0));
        // record 0: "B" / "z", field extremes
        plan.push_back(mk(REQ_NAME, 0, "B", 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_NAME, 0, 8'h00, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_NAME, 1, "z", 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_CLOSE, 0, 0, 16'hFFFF, 16'h0000, NUM_MIN, 0, 0,
                          1, ST_OK, 0, 0, 0, 0));
        // record 1: family byte 0xFF sorts last
        plan.push_back(mk(REQ_NAME, 0, 8'hFF, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_CLOSE, 0, 0, 16'h0000, 16'hFFFF, NUM_MAX, 0, 0,
                          1, ST_OK, 0, 0, 0, 0));
        // record 2: "B" with empty given name, a proper prefix of record 0
        plan.push_back(mk(REQ_NAME, 0, "B", 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_CLOSE, 0, 0, 16'd1, 16'd2, -1, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        // reads before the sort come back in load order
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK, 1, 16'h0000,
                          16'hFFFF, NUM_MAX));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 3, 1, ST_RANGE, 0, 0, 0, 0));
        // record 3: empty names, final close starts the sort
        plan.push_back(mk(REQ_CLOSE, 0, 0, 16'd3, 16'd4, 0, 1, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 3, 16'd3, 16'd4, 0));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 1, ST_OK, 2, 16'd1, 16'd2, -1));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 2, 1, ST_OK, 0, 16'hFFFF,
                          16'h0000, NUM_MIN));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 3, 1, ST_OK, 1, 16'h0000,
                          16'hFFFF, NUM_MAX));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 6'd63, 1, ST_RANGE, 0, 0, 0, 0));
        // a load after the sort opens a new, empty batch
        plan.push_back(mk(REQ_NAME, 1, "a", 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, ST_RANGE, 0, 0, 0, 0));
        plan.push_back(mk(REQ_CLOSE, 0, 0, 16'h5A5A, 16'hA5A5, 64'sd12345, 1, 0,
                          0, ST_OK, 0, 0, 0, 0));
        plan.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (plan[i])
            send(plan[i].r, plan[i].fixed, plan[i].e);

        // Random batches; once midway the sender waits for every result.
        while (items_sent < ITEM_TARGET)
        begin
            run_batch();
            if (!drained && items_sent > ITEM_TARGET / 2)
            begin
                drained = 1'b1;
                start <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            // stray noise between batches: reserved types and reads
            if ($urandom_range(0, 3) == 0)
            begin
                q = noise_req();
                q.rt = ($urandom_range(0, 1) == 0) ? REQ_READ : REQ_RSVD;
                send_checked(q);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
